### rtl/core/rbs_pkg.sv
// Shared types, codes and constants of the retry backoff sender.
package rbs_pkg;

  localparam int TIME_BITS_DEF = 48;
  localparam int FIELD_TIME_W  = 48;
  localparam int ATT_W         = 11;
  localparam int BO_W          = 32;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = 2;

  localparam logic [ATT_W-1:0] MAX_ATT_RESET = ATT_W'(1);
  localparam logic [BO_W-1:0]  BO_RESET      = BO_W'(1);

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_WAITING   = 3'd1,
    MODE_BACKOFF   = 3'd2,
    MODE_SUCCEEDED = 3'd3,
    MODE_FAILED    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ERR_OK            = 3'd0,
    ERR_TERMINAL      = 3'd1,
    ERR_PENDING       = 3'd2,
    ERR_BACKOFF       = 3'd3,
    ERR_BUDGET        = 3'd4,
    ERR_NOT_WAITING   = 3'd5,
    ERR_OK_AS_FAILURE = 3'd6,
    ERR_BAD_RESPONSE  = 3'd7
  } err_e;

  typedef enum logic [1:0] {
    ACT_BEGIN    = 2'd0,
    ACT_RESPONSE = 2'd1,
    ACT_FAILURE  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ATTEMPTS = 2'd0,
    CFG_INIT_BACKOFF = 2'd1,
    CFG_MAX_BACKOFF  = 2'd2
  } cfg_idx_e;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_UNAVAIL   = 3'd1;
  localparam logic [2:0] STATUS_EXHAUSTED = 3'd2;
  localparam logic [2:0] STATUS_IO        = 3'd3;
  localparam logic [2:0] STATUS_OTHER     = 3'd4;
  localparam logic [2:0] STATUS_NONE      = 3'd5;

  typedef struct packed {
    logic [1:0]              action;
    logic [FIELD_TIME_W-1:0] now;
    logic [2:0]              resp_status;
    logic                    response_valid;
  } in_t;

  typedef struct packed {
    logic [2:0]              error;
    logic [ATT_W-1:0]        attempt_number;
    logic [2:0]              mode;
    logic [FIELD_TIME_W-1:0] retry_not_before;
    logic [2:0]              last_status;
  } out_t;

  typedef struct packed {
    logic [ATT_W-1:0] max_attempts;
    logic [BO_W-1:0]  first_backoff;
    logic [BO_W-1:0]  max_backoff;
  } cfg_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    mode_e            mode;
    logic [ATT_W-1:0] attempts;
    logic [BO_W-1:0]  backoff;
    logic [2:0]       status;
  } state_t;

  function automatic logic is_retryable(input logic [2:0] code);
    return (code == STATUS_UNAVAIL) || (code == STATUS_EXHAUSTED) || (code == STATUS_IO);
  endfunction

endpackage

### rtl/core/rbs_cfg_regs.sv
// Configuration registers: attempt budget, initial delay and delay cap.
module rbs_cfg_regs
  import rbs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_wr_i,
  output cfg_t    cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_attempts  <= MAX_ATT_RESET;
      cfg_q.first_backoff <= BO_RESET;
      cfg_q.max_backoff   <= BO_RESET;
    end else if (cfg_wr_i.we) begin
      unique case (cfg_wr_i.idx)
        CFG_MAX_ATTEMPTS: cfg_q.max_attempts  <= cfg_wr_i.data[ATT_W-1:0];
        CFG_INIT_BACKOFF: cfg_q.first_backoff <= cfg_wr_i.data[BO_W-1:0];
        CFG_MAX_BACKOFF:  cfg_q.max_backoff   <= cfg_wr_i.data[BO_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/rbs_step_logic.sv
// Next-state logic for one event: mode checks, backoff doubling, deadline sum.
module rbs_step_logic
  import rbs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  state_t               st_i,
  input  logic [TIME_BITS-1:0] deadline_i,
  input  cfg_t                 cfg_i,
  input  in_t                  item_i,
  output state_t               st_o,
  output logic [TIME_BITS-1:0] deadline_o,
  output err_e                 err_o
);

  localparam int SUM_W = ((TIME_BITS > BO_W) ? TIME_BITS : BO_W) + 1;

  logic [63:0]          now_ext;
  logic [TIME_BITS-1:0] now_t;
  logic [2:0]           status;
  logic [SUM_W-1:0]     sum;
  logic [TIME_BITS-1:0] dl_retry;
  logic [BO_W:0]        dbl;
  logic [BO_W-1:0]      bo_next;
  logic                 retry_ok;

  always_comb begin
    now_ext = 64'(item_i.now);
    now_t   = now_ext[TIME_BITS-1:0];
    status  = (item_i.resp_status > STATUS_OTHER) ? STATUS_OTHER : item_i.resp_status;

    // Deadline saturates at the largest tick value.
    sum      = SUM_W'(now_t) + SUM_W'(st_i.backoff);
    dl_retry = ((sum >> TIME_BITS) != '0) ? '1 : sum[TIME_BITS-1:0];

    // Double the delay, clamped to the cap; a cap below the delay freezes it.
    dbl     = {st_i.backoff, 1'b0};
    bo_next = st_i.backoff;
    if (st_i.backoff < cfg_i.max_backoff) begin
      bo_next = (dbl < {1'b0, cfg_i.max_backoff}) ? dbl[BO_W-1:0] : cfg_i.max_backoff;
    end

    retry_ok = is_retryable(status) && (st_i.attempts < cfg_i.max_attempts);
  end

  always_comb begin
    st_o       = st_i;
    deadline_o = deadline_i;
    err_o      = ERR_OK;
    unique case (item_i.action)
      ACT_BEGIN: begin
        if (st_i.mode == MODE_SUCCEEDED || st_i.mode == MODE_FAILED) begin
          err_o = ERR_TERMINAL;
        end else if (st_i.mode == MODE_WAITING) begin
          err_o = ERR_PENDING;
        end else if (st_i.mode == MODE_BACKOFF && now_t < deadline_i) begin
          err_o = ERR_BACKOFF;
        end else if (st_i.attempts >= cfg_i.max_attempts) begin
          err_o = ERR_BUDGET;
        end else begin
          st_o.attempts = st_i.attempts + ATT_W'(1);
          st_o.mode     = MODE_WAITING;
          deadline_o    = '0;
        end
      end
      ACT_RESPONSE, ACT_FAILURE: begin
        if (st_i.mode != MODE_WAITING) begin
          err_o = ERR_NOT_WAITING;
        end else if (item_i.action == ACT_RESPONSE && !item_i.response_valid) begin
          err_o = ERR_BAD_RESPONSE;
        end else if (status == STATUS_OK) begin
          if (item_i.action == ACT_RESPONSE) begin
            st_o.status = STATUS_OK;
            st_o.mode   = MODE_SUCCEEDED;
            deadline_o  = '0;
          end else begin
            err_o = ERR_OK_AS_FAILURE;
          end
        end else begin
          st_o.status = status;
          if (retry_ok) begin
            st_o.mode    = MODE_BACKOFF;
            st_o.backoff = bo_next;
            deadline_o   = dl_retry;
          end else begin
            st_o.mode  = MODE_FAILED;
            deadline_o = '0;
          end
        end
      end
      default: err_o = ERR_NOT_WAITING;
    endcase
  end

endmodule

### rtl/core/rbs_sender_state.sv
// Retry state registers and the result built from their next values.
module rbs_sender_state
  import rbs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_en_i,
  input  in_t     item_i,
  input  cfg_t    cfg_i,
  input  cfg_wr_t cfg_wr_i,
  output out_t    result_o
);

  state_t               st_q, st_d;
  logic [TIME_BITS-1:0] dl_q, dl_d;
  err_e                 err;
  logic [63:0]          dl_ext;
  logic                 bo_load;

  rbs_step_logic #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .st_i      (st_q),
    .deadline_i(dl_q),
    .cfg_i     (cfg_i),
    .item_i    (item_i),
    .st_o      (st_d),
    .deadline_o(dl_d),
    .err_o     (err)
  );

  // A new initial delay takes effect at once only before the first attempt.
  assign bo_load = cfg_wr_i.we && (cfg_wr_i.idx == CFG_INIT_BACKOFF) &&
                   (st_q.mode == MODE_IDLE) && (st_q.attempts == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode     <= MODE_IDLE;
      st_q.attempts <= '0;
      st_q.backoff  <= BO_RESET;
      st_q.status   <= STATUS_NONE;
      dl_q          <= '0;
    end else if (step_en_i) begin
      st_q <= st_d;
      dl_q <= dl_d;
    end else if (bo_load) begin
      st_q.backoff <= cfg_wr_i.data[BO_W-1:0];
    end
  end

  always_comb begin
    dl_ext                    = 64'(dl_d);
    result_o.error            = err;
    result_o.attempt_number   = st_d.attempts;
    result_o.mode             = st_d.mode;
    result_o.retry_not_before = dl_ext[FIELD_TIME_W-1:0];
    result_o.last_status      = st_d.status;
  end

endmodule

### rtl/core/retry_backoff_sender_unit.sv
// Top level of the retry backoff sender: request and result registers around the state.
//
// Usage: each request on the in channel (in_valid_i/in_ready_o, payload in_data_i)
// is one event for a single outstanding request: begin an attempt, a response
// arrived, or a transport failure, stamped with the current tick. Every request
// yields exactly one result on the out channel (out_valid_o/out_ready_i,
// payload out_data_o) holding the error code and the state after the event.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes the attempt
// budget, the initial delay and the delay cap; write it only while idle.
// A request passes two registers, the request register and the result register,
// before its result is valid; while the out channel stalls it waits in the first.
// Throughput: one request per cycle while the receiver keeps up; the event logic is
// one add and a few compares between the request, state and result registers.
// Reset: mode idle, no attempts, status none, delay and config registers at 1.
// When the receiver stalls, the result register holds and the request register
// still takes one more request before in_ready_o drops.
module retry_backoff_sender_unit
  import rbs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  in_t     req_q;
  logic    req_v_q;
  out_t    out_q;
  logic    out_v_q;
  logic    step_fire;
  out_t    result;
  cfg_t    cfg;
  cfg_wr_t cfg_wr;

  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_i;
  assign cfg_wr.data = cfg_wdata_i;

  rbs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_wr_i(cfg_wr),
    .cfg_o   (cfg)
  );

  rbs_sender_state #(
    .TIME_BITS(TIME_BITS)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_en_i(step_fire),
    .item_i   (req_q),
    .cfg_i    (cfg),
    .cfg_wr_i (cfg_wr),
    .result_o (result)
  );

  assign step_fire  = req_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !req_v_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        req_v_q <= in_valid_i;
      end
      if (step_fire) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_data_i;
    end
    if (step_fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // A held request must not be lost or overwritten while the result side stalls.
  a_req_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_v_q && !step_fire |=> req_v_q && $stable(req_q))
    else $error("held request was dropped or overwritten");

  // Only the backoff mode carries a retry deadline.
  a_deadline_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.mode != MODE_BACKOFF) |-> out_data_o.retry_not_before == '0)
    else $error("deadline set outside backoff mode");

  // Success is only reached through an ok status.
  a_success_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.mode == MODE_SUCCEEDED) |-> out_data_o.last_status == STATUS_OK)
    else $error("succeeded without an ok status");
`endif

endmodule

### tb/tb.sv
// Testbench for the retry backoff sender: directed and random events checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbs_pkg::*;

  localparam logic [FIELD_TIME_W-1:0] TICK_MAX = '1;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam logic [2:0] STATUS_TOP = 3'd7;
  localparam int BUDGET_MAX = 1024;
  localparam int SQUEEZE_CYCLES = 64;
  localparam int RUN_LIMIT_NS = 2_400_000;

  typedef struct packed {
    mode_e                   mode;
    logic [ATT_W-1:0]        tries;
    logic [BO_W-1:0]         delay;
    logic [FIELD_TIME_W-1:0] not_before;
    logic [2:0]              status;
  } sender_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_t                  out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // Register copies shared by the planning and the checking state; they only
  // change while nothing is in flight.
  logic [ATT_W-1:0] budget_reg;
  logic [BO_W-1:0]  delay_cap_reg;

  sender_t plan_st;  // state after every request queued so far
  sender_t sent_st;  // state after every request accepted so far

  in_t  req_fifo[$];
  out_t expected_outcomes[$];
  out_t accepted_outcome;
  out_t want;
  bit   req_taken;
  int   n_accepted;
  int   n_checked;
  int   n_mismatch;
  int   err_seen[8];
  int   squeeze_left;
  bit   squeeze_done;

  retry_backoff_sender_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit is_done(mode_e m);
    return (m == MODE_SUCCEEDED) || (m == MODE_FAILED);
  endfunction

  function automatic void schedule_retry(inout sender_t s, input logic [2:0] code,
                                         input logic [FIELD_TIME_W-1:0] now);
    logic [BO_W:0] doubled;
    s.status = code;
    if (!((code == STATUS_UNAVAIL) || (code == STATUS_EXHAUSTED) || (code == STATUS_IO)) ||
        s.tries >= budget_reg) begin
      s.mode = MODE_FAILED;
      s.not_before = '0;
      return;
    end
    s.mode = MODE_BACKOFF;
    if (FIELD_TIME_W'(s.delay) > TICK_MAX - now) begin
      s.not_before = TICK_MAX;
    end else begin
      s.not_before = now + FIELD_TIME_W'(s.delay);
    end
    // The delay doubles toward the cap and is never raised past it; a delay at or above the cap stays as it is.
    if (s.delay < delay_cap_reg) begin
      doubled = {s.delay, 1'b0};
      if (s.delay > (delay_cap_reg >> 1)) begin
        s.delay = delay_cap_reg;
      end else if (doubled < {1'b0, delay_cap_reg}) begin
        s.delay = doubled[BO_W-1:0];
      end else begin
        s.delay = delay_cap_reg;
      end
    end
  endfunction

  function automatic void advance_sender(inout sender_t s, input in_t req, output out_t res);
    logic [2:0] code;
    err_e       err;
    code = (req.resp_status > STATUS_OTHER) ? STATUS_OTHER : req.resp_status;
    err = ERR_OK;
    case (req.action)
      ACT_BEGIN: begin
        if (is_done(s.mode)) begin
          err = ERR_TERMINAL;
        end else if (s.mode == MODE_WAITING) begin
          err = ERR_PENDING;
        end else if (s.mode == MODE_BACKOFF && req.now < s.not_before) begin
          err = ERR_BACKOFF;
        end else if (s.tries >= budget_reg) begin
          err = ERR_BUDGET;
        end else begin
          s.tries = s.tries + ATT_W'(1);
          s.mode = MODE_WAITING;
          s.not_before = '0;
        end
      end
      ACT_RESPONSE: begin
        if (s.mode != MODE_WAITING) begin
          err = ERR_NOT_WAITING;
        end else if (!req.response_valid) begin
          err = ERR_BAD_RESPONSE;
        end else if (code == STATUS_OK) begin
          s.status = STATUS_OK;
          s.mode = MODE_SUCCEEDED;
          s.not_before = '0;
        end else begin
          schedule_retry(s, code, req.now);
        end
      end
      ACT_FAILURE: begin
        if (s.mode != MODE_WAITING) begin
          err = ERR_NOT_WAITING;
        end else if (code == STATUS_OK) begin
          err = ERR_OK_AS_FAILURE;
        end else begin
          schedule_retry(s, code, req.now);
        end
      end
      default: err = ERR_NOT_WAITING;
    endcase
    res.error = err;
    res.attempt_number = s.tries;
    res.mode = s.mode;
    res.retry_not_before = s.not_before;
    res.last_status = s.status;
  endfunction

  task automatic add_req(input logic [1:0] act, input logic [FIELD_TIME_W-1:0] now,
                         input logic [2:0] code, input logic ok);
    in_t  r;
    out_t ignored;
    r.action = act;
    r.now = now;
    r.resp_status = code;
    r.response_valid = ok;
    advance_sender(plan_st, r, ignored);
    req_fifo.insert(req_fifo.size(), r);
  endtask

  // Mostly events that move the request forward, the rest noise; the request
  // is kept out of its final modes until the run chooses how it ends.
  task automatic add_random_req();
    in_t         r;
    sender_t     probe;
    out_t        ignored;
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    r.action = 2'($urandom_range(0, 3));
    r.now = rnd[FIELD_TIME_W-1:0];
    r.resp_status = 3'($urandom_range(0, 7));
    r.response_valid = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 82) begin
      if (plan_st.mode == MODE_WAITING) begin
        r.action = $urandom_range(0, 1) ? ACT_RESPONSE : ACT_FAILURE;
        r.resp_status = 3'($urandom_range(STATUS_UNAVAIL, STATUS_IO));
        r.response_valid = 1'b1;
        case ($urandom_range(0, 7))
          0: r.now = TICK_MAX - FIELD_TIME_W'($urandom_range(0, 4095));
          1: r.now = FIELD_TIME_W'($urandom_range(0, 4095));
          default: ;
        endcase
      end else begin
        r.action = ACT_BEGIN;
        case ($urandom_range(0, 5))
          0: ;
          1: r.now = plan_st.not_before - FIELD_TIME_W'(1);
          2: r.now = plan_st.not_before;
          default: begin
            if (plan_st.not_before > TICK_MAX - FIELD_TIME_W'(1000)) begin
              r.now = TICK_MAX;
            end else begin
              r.now = plan_st.not_before + FIELD_TIME_W'($urandom_range(0, 999));
            end
          end
        endcase
      end
    end
    probe = plan_st;
    advance_sender(probe, r, ignored);
    if (!is_done(plan_st.mode) && is_done(probe.mode)) begin
      r.action = ACT_RESPONSE;
      r.response_valid = 1'b0;
    end
    advance_sender(plan_st, r, ignored);
    req_fifo.insert(req_fifo.size(), r);
  endtask

  task automatic wait_quiet();
    while (req_fifo.size() != 0 || in_valid_i || expected_outcomes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_ATTEMPTS: budget_reg = val[ATT_W-1:0];
      CFG_INIT_BACKOFF: begin
        // The first delay only takes effect before any attempt has started.
        if (sent_st.mode == MODE_IDLE && sent_st.tries == '0) begin
          sent_st.delay = val;
          plan_st.delay = val;
        end
      end
      CFG_MAX_BACKOFF: delay_cap_reg = val;
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string msg);
    $display("mismatch on result %0d: %s", n_checked, msg);
    n_mismatch++;
  endtask

  task automatic check_field(input string name, input logic [FIELD_TIME_W-1:0] got,
                             input logic [FIELD_TIME_W-1:0] exp);
    if (got !== exp) begin
      flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp));
    end
  endtask

  function automatic bit take_break(int n);
    return (n < 200 || n >= 400) && ($urandom_range(0, 99) < 17);
  endfunction

  // Request side: acceptance is seen at the rising edge, the next request is
  // offered at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      advance_sender(sent_st, in_data_i, accepted_outcome);
      expected_outcomes.insert(expected_outcomes.size(), accepted_outcome);
      n_accepted++;
      req_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      req_taken = 1'b0;
      if (req_fifo.size() != 0 && !take_break(n_accepted)) begin
        in_data_i <= req_fifo.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // One long hold-off on the result side so that the block backs up.
  always @(posedge clk_i) begin
    if (!squeeze_done && n_checked >= 450) begin
      squeeze_done <= 1'b1;
      squeeze_left <= SQUEEZE_CYCLES;
    end else if (squeeze_left > 0) begin
      squeeze_left <= squeeze_left - 1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= (squeeze_left == 0) && !take_break(n_checked);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_outcomes.size() == 0) begin
        flag_mismatch("result arrived with no request outstanding");
      end else begin
        want = expected_outcomes.pop_front();
        check_field("error", FIELD_TIME_W'(out_data_o.error), FIELD_TIME_W'(want.error));
        check_field("attempt_number", FIELD_TIME_W'(out_data_o.attempt_number),
                    FIELD_TIME_W'(want.attempt_number));
        check_field("mode", FIELD_TIME_W'(out_data_o.mode), FIELD_TIME_W'(want.mode));
        check_field("retry_not_before", out_data_o.retry_not_before, want.retry_not_before);
        check_field("last_status", FIELD_TIME_W'(out_data_o.last_status),
                    FIELD_TIME_W'(want.last_status));
        err_seen[out_data_o.error]++;
      end
      n_checked++;
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results still outstanding", expected_outcomes.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sender_t     fresh;
    logic [63:0] rnd;
    int          ending;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    squeeze_left = 0;
    squeeze_done = 1'b0;
    budget_reg = MAX_ATT_RESET;
    delay_cap_reg = BO_RESET;
    fresh.mode = MODE_IDLE;
    fresh.tries = '0;
    fresh.delay = BO_RESET;
    fresh.not_before = '0;
    fresh.status = STATUS_NONE;
    plan_st = fresh;
    sent_st = fresh;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Events that find no request in flight.
    add_req(ACT_RESPONSE, 48'd5, STATUS_OK, 1'b1);
    add_req(ACT_FAILURE, TICK_MAX, STATUS_IO, 1'b1);
    add_req(ACT_UNKNOWN, 48'd0, STATUS_TOP, 1'b0);
    wait_quiet();
    write_reg(CFG_MAX_ATTEMPTS, 32'd0);
    add_req(ACT_BEGIN, 48'd0, STATUS_OK, 1'b0);
    wait_quiet();
    // Cap below the first delay: the delay stays put until the cap rises.
    write_reg(CFG_MAX_ATTEMPTS, 32'(BUDGET_MAX));
    write_reg(CFG_INIT_BACKOFF, 32'd3);
    write_reg(CFG_MAX_BACKOFF, 32'd2);
    add_req(ACT_BEGIN, 48'd0, STATUS_OK, 1'b1);
    add_req(ACT_BEGIN, 48'd1, STATUS_OK, 1'b1);
    add_req(ACT_RESPONSE, 48'd2, STATUS_NONE, 1'b0);
    add_req(ACT_FAILURE, 48'd3, STATUS_OK, 1'b1);
    add_req(ACT_FAILURE, TICK_MAX - FIELD_TIME_W'(1), STATUS_UNAVAIL, 1'b1);
    add_req(ACT_RESPONSE, 48'd4, STATUS_OK, 1'b1);
    add_req(ACT_BEGIN, TICK_MAX - FIELD_TIME_W'(1), STATUS_OK, 1'b0);
    add_req(ACT_BEGIN, TICK_MAX, STATUS_OK, 1'b0);
    add_req(ACT_RESPONSE, 48'd100, STATUS_EXHAUSTED, 1'b1);
    add_req(ACT_BEGIN, 48'd102, STATUS_OK, 1'b0);
    add_req(ACT_BEGIN, 48'd103, STATUS_OK, 1'b0);
    add_req(ACT_FAILURE, 48'd0, STATUS_IO, 1'b1);
    add_req(ACT_FAILURE, 48'd1, STATUS_IO, 1'b1);
    add_req(ACT_UNKNOWN, 48'd2, STATUS_OK, 1'b1);
    wait_quiet();
    // A new first delay is ignored once attempts have started.
    write_reg(CFG_INIT_BACKOFF, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_BACKOFF, 32'd1000);
    add_req(ACT_BEGIN, 48'd3, STATUS_OK, 1'b0);
    add_req(ACT_RESPONSE, 48'd50, STATUS_UNAVAIL, 1'b1);

    for (int p = 0; p < 5; p++) begin
      for (int k = 0; k < 140; k++) begin
        add_random_req();
      end
      wait_quiet();
      if (p == 1) begin
        // Budget held at the attempt count while backing off.
        if (plan_st.mode == MODE_WAITING) begin
          add_req(ACT_FAILURE, TICK_MAX - FIELD_TIME_W'(10), STATUS_UNAVAIL, 1'b1);
          wait_quiet();
        end
        write_reg(CFG_MAX_ATTEMPTS, 32'(plan_st.tries));
        add_req(ACT_BEGIN, TICK_MAX, STATUS_OK, 1'b0);
        repeat (6) add_random_req();
        wait_quiet();
        write_reg(CFG_MAX_ATTEMPTS, 32'(BUDGET_MAX));
      end
      case (p)
        0: write_reg(CFG_MAX_BACKOFF, 32'h0001_0000);
        1: write_reg(CFG_MAX_BACKOFF, 32'h0004_0000);
        2: write_reg(CFG_MAX_BACKOFF, $urandom | 32'd1);
        3: write_reg(CFG_MAX_BACKOFF, 32'hFFFF_FFFF);
        default: ;
      endcase
      write_reg(CFG_INIT_BACKOFF, $urandom);
    end

    // The request ends in one of its final modes, chosen at random.
    if (plan_st.mode != MODE_WAITING) begin
      add_req(ACT_BEGIN, TICK_MAX, STATUS_OK, 1'b0);
    end
    rnd = {$urandom, $urandom};
    ending = $urandom_range(0, 3);
    case (ending)
      0: add_req(ACT_RESPONSE, rnd[FIELD_TIME_W-1:0], STATUS_OK, 1'b1);
      1: add_req(ACT_RESPONSE, rnd[FIELD_TIME_W-1:0],
                 3'($urandom_range(STATUS_OTHER, STATUS_TOP)), 1'b1);
      2: add_req(ACT_FAILURE, rnd[FIELD_TIME_W-1:0],
                 3'($urandom_range(STATUS_OTHER, STATUS_TOP)), 1'b0);
      default: begin
        wait_quiet();
        write_reg(CFG_MAX_ATTEMPTS, 32'(plan_st.tries));
        add_req(ACT_FAILURE, rnd[FIELD_TIME_W-1:0], STATUS_EXHAUSTED, 1'b1);
      end
    endcase
    add_req(ACT_BEGIN, TICK_MAX, STATUS_OK, 1'b0);
    repeat (12) add_random_req();
    wait_quiet();

    $display("checked %0d results of %0d requests; by error: ok %0d terminal %0d pending %0d",
             n_checked, n_accepted, err_seen[ERR_OK], err_seen[ERR_TERMINAL],
             err_seen[ERR_PENDING]);
    $display("backoff %0d budget %0d not-waiting %0d ok-as-failure %0d bad %0d; final mode %0d",
             err_seen[ERR_BACKOFF], err_seen[ERR_BUDGET], err_seen[ERR_NOT_WAITING],
             err_seen[ERR_OK_AS_FAILURE], err_seen[ERR_BAD_RESPONSE], sent_st.mode);
    if (n_mismatch == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/rbs_pkg.sv
rtl/core/rbs_cfg_regs.sv
rtl/core/rbs_step_logic.sv
rtl/core/rbs_sender_state.sv
rtl/core/retry_backoff_sender_unit.sv
tb/tb.sv
